### hw/rtl/ebpf_pkg.sv
// ----------------------------------------------------------------------------
// ebpf_pkg
// Shared types and constants of the ebpf subset interpreter.
// ----------------------------------------------------------------------------
package ebpf_pkg;

  localparam logic [1:0] KindProg = 2'd0;
  localparam logic [1:0] KindCtx  = 2'd1;
  localparam logic [1:0] KindRun  = 2'd2;

  localparam logic [1:0] CfgProgLen   = 2'd0;
  localparam logic [1:0] CfgStepLimit = 2'd1;

  localparam logic [1:0] CauseExit  = 2'd0;
  localparam logic [1:0] CausePc    = 2'd1;
  localparam logic [1:0] CauseSteps = 2'd2;

  localparam logic [2:0] ClsLdx = 3'h1;
  localparam logic [2:0] ClsJmp = 3'h5;
  localparam logic [2:0] ClsAlu = 3'h7;

  localparam logic [3:0] OpAdd  = 4'h0;
  localparam logic [3:0] OpSub  = 4'h1;
  localparam logic [3:0] OpOr   = 4'h4;
  localparam logic [3:0] OpAnd  = 4'h5;
  localparam logic [3:0] OpLsh  = 4'h6;
  localparam logic [3:0] OpRsh  = 4'h7;
  localparam logic [3:0] OpXor  = 4'hA;
  localparam logic [3:0] OpMov  = 4'hB;

  localparam logic [3:0] OpJa   = 4'h0;
  localparam logic [3:0] OpJeq  = 4'h1;
  localparam logic [3:0] OpJgt  = 4'h2;
  localparam logic [3:0] OpJne  = 4'h5;
  localparam logic [3:0] OpCall = 4'h8;
  localparam logic [3:0] OpExit = 4'h9;

  localparam int unsigned NumRegs = 11;
  localparam logic [63:0] StackBase = 64'h0010_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FETCH,
    ST_EXEC,
    ST_LOAD,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic fetch;
    logic exec;
    logic load_wb;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic pc_out;
    logic steps_out;
    logic is_exit;
    logic is_load;
  } stat_t;

endpackage

### hw/rtl/ebpf_ctrl.sv
// ----------------------------------------------------------------------------
// ebpf_ctrl
// Run sequencer: clear, fetch, execute, load writeback, done.
// ----------------------------------------------------------------------------
module ebpf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             run_i,
  input  ebpf_pkg::stat_t  stat_i,
  output ebpf_pkg::ctrl_t  ctrl_o,
  output logic             busy_o,
  output logic             done_o
);

  ebpf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ebpf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ebpf_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (run_i) begin
          state_d = ebpf_pkg::ST_CLEAR;
        end
      end
      ebpf_pkg::ST_CLEAR: begin
        ctrl_o.clear = 1'b1;
        state_d = ebpf_pkg::ST_FETCH;
      end
      ebpf_pkg::ST_FETCH: begin
        if (stat_i.pc_out || stat_i.steps_out) begin
          state_d = ebpf_pkg::ST_DONE;
        end else begin
          ctrl_o.fetch = 1'b1;
          state_d = ebpf_pkg::ST_EXEC;
        end
      end
      ebpf_pkg::ST_EXEC: begin
        ctrl_o.exec = 1'b1;
        if (stat_i.is_exit) begin
          state_d = ebpf_pkg::ST_DONE;
        end else if (stat_i.is_load) begin
          state_d = ebpf_pkg::ST_LOAD;
        end else begin
          state_d = ebpf_pkg::ST_FETCH;
        end
      end
      ebpf_pkg::ST_LOAD: begin
        ctrl_o.load_wb = 1'b1;
        state_d = ebpf_pkg::ST_FETCH;
      end
      ebpf_pkg::ST_DONE: begin
        done_o  = 1'b1;
        state_d = ebpf_pkg::ST_IDLE;
      end
      default: state_d = ebpf_pkg::ST_IDLE;
    endcase
  end

  ctrl_exclusive_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({ctrl_o.clear, ctrl_o.fetch, ctrl_o.exec, ctrl_o.load_wb, done_o}) <= 1)
    else $error("more than one command at once");
  done_then_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("not idle after done");
  run_clears_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_i && !busy_o) |=> ctrl_o.clear)
    else $error("run did not clear");
  load_after_exec_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load_wb |-> $past(ctrl_o.exec))
    else $error("load writeback without execute");

endmodule

### hw/rtl/ebpf_dp.sv
// ----------------------------------------------------------------------------
// ebpf_dp
// Datapath: program and context memories, register file, alu, jumps, loads.
// ----------------------------------------------------------------------------
module ebpf_dp #(
  parameter int unsigned PROG_DEPTH  = 256,
  parameter int unsigned CTX_WORDS   = 32,
  parameter int unsigned STACK_BYTES = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_prog_i,
  input  logic             wr_ctx_i,
  input  logic [7:0]       index_i,
  input  logic [63:0]      word_i,
  input  logic [8:0]       program_length_i,
  input  logic [19:0]      step_limit_i,
  input  ebpf_pkg::ctrl_t  ctrl_i,
  output ebpf_pkg::stat_t  stat_o,
  output logic [63:0]      return_value_o,
  output logic             bad_access_o,
  output logic [19:0]      steps_used_o
);

  localparam int unsigned PaW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
  localparam int unsigned CaW = (CTX_WORDS > 1) ? $clog2(CTX_WORDS) : 1;
  localparam int unsigned LenW = $clog2(PROG_DEPTH + 1);
  localparam logic [63:0] CtxLast = 64'(CTX_WORDS) * 64'd8 - 64'd8;
  localparam logic [63:0] StkLast = 64'(STACK_BYTES) - 64'd8;
  localparam logic [63:0] StkTop = ebpf_pkg::StackBase + 64'(STACK_BYTES);

  logic [63:0] prog_mem [PROG_DEPTH];
  logic [63:0] ctx_mem [CTX_WORDS];
  logic [63:0] insn_q;
  logic [63:0] ctx_lo_q, ctx_hi_q;
  logic [5:0]  lsh_q;
  logic        ld_ctx_q;
  logic [3:0]  ld_dst_q;
  logic [63:0] regs_q [ebpf_pkg::NumRegs];
  logic [31:0] pc_q;
  logic [19:0] steps_q;
  logic        fault_q;

  // program memory: write port for load items, read port for fetch
  always_ff @(posedge clk_i) begin
    if (wr_prog_i && (32'(index_i) < PROG_DEPTH)) begin
      prog_mem[PaW'(index_i)] <= word_i;
    end
    if (ctrl_i.fetch) begin
      insn_q <= prog_mem[pc_q[PaW-1:0]];
    end
  end

  // decode
  logic [7:0]  opc;
  logic [3:0]  dst, src, op;
  logic [2:0]  cls;
  logic [63:0] off64, imm64, sv, dv, alu_res, addr, rel;
  logic        ld_ok_ctx, ld_ok_stk, take;

  always_comb begin
    opc   = insn_q[7:0];
    dst   = insn_q[11:8];
    src   = insn_q[15:12];
    cls   = opc[2:0];
    op    = opc[7:4];
    off64 = {{48{insn_q[31]}}, insn_q[31:16]};
    imm64 = {{32{insn_q[63]}}, insn_q[63:32]};
    dv    = (32'(dst) < ebpf_pkg::NumRegs) ? regs_q[dst] : 64'd0;
    sv    = opc[3] ? ((32'(src) < ebpf_pkg::NumRegs) ? regs_q[src] : 64'd0) : imm64;
    unique case (op)
      ebpf_pkg::OpAdd: alu_res = dv + sv;
      ebpf_pkg::OpSub: alu_res = dv - sv;
      ebpf_pkg::OpOr:  alu_res = dv | sv;
      ebpf_pkg::OpAnd: alu_res = dv & sv;
      ebpf_pkg::OpLsh: alu_res = dv << sv[5:0];
      ebpf_pkg::OpRsh: alu_res = dv >> sv[5:0];
      ebpf_pkg::OpXor: alu_res = dv ^ sv;
      ebpf_pkg::OpMov: alu_res = sv;
      default:         alu_res = dv;
    endcase
    unique case (op)
      ebpf_pkg::OpJa:  take = 1'b1;
      ebpf_pkg::OpJeq: take = (dv == sv);
      ebpf_pkg::OpJgt: take = (dv > sv);
      ebpf_pkg::OpJne: take = (dv != sv);
      default:         take = 1'b0;
    endcase
    addr      = ((32'(src) < ebpf_pkg::NumRegs) ? regs_q[src] : 64'd0) + off64;
    rel       = addr - ebpf_pkg::StackBase;
    ld_ok_ctx = (addr <= CtxLast);
    ld_ok_stk = (addr >= ebpf_pkg::StackBase) && (rel <= StkLast);
  end

  // context memory: two read words cover an unaligned 8-byte load
  logic [CaW-1:0] ctx_a0, ctx_a1;
  assign ctx_a0 = CaW'(addr >> 3);
  assign ctx_a1 = CaW'((addr >> 3) + 64'd1);

  always_ff @(posedge clk_i) begin
    if (wr_ctx_i && (32'(index_i) < CTX_WORDS)) begin
      ctx_mem[CaW'(index_i)] <= word_i;
    end
    if (ctrl_i.exec) begin
      ctx_lo_q <= ctx_mem[ctx_a0];
      ctx_hi_q <= ctx_mem[ctx_a1];
      lsh_q    <= {addr[2:0], 3'b000};
      ld_ctx_q <= ld_ok_ctx;
      ld_dst_q <= dst;
    end
  end

  logic [127:0] ld_pair;
  logic [63:0]  ld_val;
  assign ld_pair = {ctx_hi_q, ctx_lo_q} >> lsh_q;
  assign ld_val  = ld_ctx_q ? ld_pair[63:0] : 64'd0;

  logic [LenW-1:0] len;
  assign len = (32'(program_length_i) > PROG_DEPTH) ? LenW'(PROG_DEPTH)
                                                   : LenW'(program_length_i);

  assign stat_o.pc_out    = (pc_q >= 32'(len));
  assign stat_o.steps_out = (steps_q >= step_limit_i);
  assign stat_o.is_exit   = (cls == ebpf_pkg::ClsJmp) && (op == ebpf_pkg::OpExit);
  assign stat_o.is_load   = (cls == ebpf_pkg::ClsLdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ebpf_pkg::NumRegs; i++) regs_q[i] <= '0;
      pc_q    <= '0;
      steps_q <= '0;
      fault_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      // r10 starts at the stack top, all others at zero
      for (int i = 0; i < ebpf_pkg::NumRegs; i++) regs_q[i] <= (i == 10) ? StkTop : 64'd0;
      pc_q    <= '0;
      steps_q <= '0;
      fault_q <= 1'b0;
    end else if (ctrl_i.fetch) begin
      steps_q <= steps_q + 20'd1;
    end else if (ctrl_i.exec) begin
      if (!stat_o.is_exit) begin
        pc_q <= pc_q + 32'd1 + ((cls == ebpf_pkg::ClsJmp && take) ? off64[31:0] : 32'd0);
      end
      if (cls == ebpf_pkg::ClsAlu && 32'(dst) < ebpf_pkg::NumRegs) begin
        regs_q[dst] <= alu_res;
      end
      if (cls == ebpf_pkg::ClsJmp && op == ebpf_pkg::OpCall) begin
        regs_q[0] <= '0;
      end
      if (cls == ebpf_pkg::ClsLdx && !ld_ok_ctx && !ld_ok_stk) begin
        fault_q <= 1'b1;
      end
    end else if (ctrl_i.load_wb) begin
      if (32'(ld_dst_q) < ebpf_pkg::NumRegs) begin
        regs_q[ld_dst_q] <= ld_val;
      end
    end
  end

  assign return_value_o = regs_q[0];
  assign bad_access_o   = fault_q;
  assign steps_used_o   = steps_q;

  steps_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.fetch |-> (steps_q < step_limit_i))
    else $error("fetch beyond step limit");
  clear_resets_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> (pc_q == 32'd0 && steps_q == 20'd0 && !fault_q))
    else $error("run state not cleared");
  fetch_counts_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.fetch |=> (steps_q == $past(steps_q) + 20'd1))
    else $error("step count not advanced");

endmodule

### hw/rtl/ebpf_subset_interpreter.sv
// ----------------------------------------------------------------------------
// ebpf_subset_interpreter
// Small ebpf interpreter: load program and context words, run, report r0.
// ----------------------------------------------------------------------------
// load items write one program or context word; a run item passes the clear state,
// then fetch and execute for each instruction, with a load writeback state after
// each load, then done; a run that stops on pc or step limit instead of exit goes
// from fetch to done (fetch, execute and load writeback states over one program memory read port).
// done_o strobes the result for one cycle; the receiver cannot stall.
// reset clears the sequencer, register file and config to their defaults.
module ebpf_subset_interpreter #(
  parameter int unsigned PROG_DEPTH  = 256,
  parameter int unsigned CTX_WORDS   = 32,
  parameter int unsigned STACK_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  index_i,
  input  logic [63:0] word_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i,
  output logic        done_o,
  output logic [63:0] return_value_o,
  output logic [1:0]  stop_cause_o,
  output logic        bad_access_o,
  output logic [19:0] steps_used_o
);

  logic [8:0]  program_length_q;
  logic [19:0] step_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      program_length_q <= '0;
      step_limit_q     <= 20'd100000;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ebpf_pkg::CfgProgLen) begin
        program_length_q <= cfg_data_i[8:0];
      end else if (cfg_idx_i == ebpf_pkg::CfgStepLimit) begin
        step_limit_q <= cfg_data_i;
      end
    end
  end

  logic            accept;
  ebpf_pkg::ctrl_t ctrl;
  ebpf_pkg::stat_t stat;
  logic            stop_exit_q;

  assign accept = start && !busy;

  ebpf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .run_i  (start && kind_i == ebpf_pkg::KindRun),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy),
    .done_o (done_o)
  );

  ebpf_dp #(
    .PROG_DEPTH  (PROG_DEPTH),
    .CTX_WORDS   (CTX_WORDS),
    .STACK_BYTES (STACK_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .wr_prog_i        (accept && kind_i == ebpf_pkg::KindProg),
    .wr_ctx_i         (accept && kind_i == ebpf_pkg::KindCtx),
    .index_i          (index_i),
    .word_i           (word_i),
    .program_length_i (program_length_q),
    .step_limit_i     (step_limit_q),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .return_value_o   (return_value_o),
    .bad_access_o     (bad_access_o),
    .steps_used_o     (steps_used_o)
  );

  // remember whether the run ended on exit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_exit_q <= 1'b0;
    end else if (ctrl.clear) begin
      stop_exit_q <= 1'b0;
    end else if (ctrl.exec && stat.is_exit) begin
      stop_exit_q <= 1'b1;
    end
  end

  always_comb begin
    priority if (stop_exit_q) begin
      stop_cause_o = ebpf_pkg::CauseExit;
    end else if (stat.pc_out) begin
      stop_cause_o = ebpf_pkg::CausePc;
    end else begin
      stop_cause_o = ebpf_pkg::CauseSteps;
    end
  end

endmodule
